@@ rtl/core/utf8e_pkg.sv @@
// shared types, codes and helper functions of the utf-8 escape transcoder
package utf8e_pkg;

    // mode register codes (the unused code behaves as transcode)
    localparam logic [1:0] MODE_TRANSCODE = 2'd0;
    localparam logic [1:0] MODE_ESCAPE    = 2'd1;
    localparam logic [1:0] MODE_UNESCAPE  = 2'd2;

    // register word index on the config bus
    localparam logic REG_MODE = 1'b0;

    // characters with special handling
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;

    // results buffered per input word
    localparam int MAX_RES = 8;

    // input and output words
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_lead;
        logic       last_of_run;
    } t_out_word;

    // one buffered result before the last flag is attached
    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_lead;
    } t_res;

    // shortest utf-8 form of one code point
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    // bytes produced by one code point, with the backslash flag it leaves
    typedef struct packed {
        logic [6:0][7:0] bytes;
        logic [2:0]      len;
        logic            bs_pending;
    } t_emit;

    // shift the gathered bits up over the missing continuation groups
    function automatic logic [30:0] pad_code(logic [30:0] acc, logic [2:0] n);
        logic [30:0] r;
        unique case (n)
            3'd0:    r = acc;
            3'd1:    r = {acc[24:0], 6'b0};
            3'd2:    r = {acc[18:0], 12'b0};
            3'd3:    r = {acc[12:0], 18'b0};
            3'd4:    r = {acc[6:0], 24'b0};
            default: r = {acc[0], 30'b0};
        endcase
        return r;
    endfunction

    // minimal utf-8 encoding, lead byte in entry 0
    function automatic t_enc encode(logic [30:0] c);
        t_enc e;
        e = '0;
        priority if (c < 31'h80) begin
            e.len      = 3'd1;
            e.bytes[0] = {1'b0, c[6:0]};
        end else if (c < 31'h800) begin
            e.len      = 3'd2;
            e.bytes[0] = {3'b110, c[10:6]};
            e.bytes[1] = {2'b10, c[5:0]};
        end else if (c < 31'h10000) begin
            e.len      = 3'd3;
            e.bytes[0] = {4'b1110, c[15:12]};
            e.bytes[1] = {2'b10, c[11:6]};
            e.bytes[2] = {2'b10, c[5:0]};
        end else if (c < 31'h200000) begin
            e.len      = 3'd4;
            e.bytes[0] = {5'b11110, c[20:18]};
            e.bytes[1] = {2'b10, c[17:12]};
            e.bytes[2] = {2'b10, c[11:6]};
            e.bytes[3] = {2'b10, c[5:0]};
        end else if (c < 31'h4000000) begin
            e.len      = 3'd5;
            e.bytes[0] = {6'b111110, c[25:24]};
            e.bytes[1] = {2'b10, c[23:18]};
            e.bytes[2] = {2'b10, c[17:12]};
            e.bytes[3] = {2'b10, c[11:6]};
            e.bytes[4] = {2'b10, c[5:0]};
        end else begin
            e.len      = 3'd6;
            e.bytes[0] = {7'b1111110, c[30]};
            e.bytes[1] = {2'b10, c[29:24]};
            e.bytes[2] = {2'b10, c[23:18]};
            e.bytes[3] = {2'b10, c[17:12]};
            e.bytes[4] = {2'b10, c[11:6]};
            e.bytes[5] = {2'b10, c[5:0]};
        end
        return e;
    endfunction

    // apply the mode to one decoded code point
    function automatic t_emit emit_char(logic [1:0] mode, logic bp, logic [30:0] c);
        t_emit       e;
        t_enc        enc;
        logic [30:0] cc;
        e            = '0;
        e.bs_pending = bp;
        cc           = c;
        if (mode == MODE_UNESCAPE) begin
            if (bp) begin
                // partner of a pending backslash
                e.bs_pending = 1'b0;
                if (c == 31'(CH_N)) begin
                    cc = 31'(CH_LF);
                end else if (c == 31'(CH_R)) begin
                    cc = 31'(CH_CR);
                end
                enc     = encode(cc);
                e.bytes = {8'h00, enc.bytes};
                e.len   = enc.len;
            end else if (c == 31'(CH_BACKSLASH)) begin
                e.bs_pending = 1'b1;
            end else begin
                enc     = encode(cc);
                e.bytes = {8'h00, enc.bytes};
                e.len   = enc.len;
            end
        end else if (mode == MODE_ESCAPE) begin
            if (c == 31'(CH_LF)) begin
                e.bytes[0] = CH_BACKSLASH;
                e.bytes[1] = CH_N;
                e.len      = 3'd2;
            end else if (c == 31'(CH_CR)) begin
                e.bytes[0] = CH_BACKSLASH;
                e.bytes[1] = CH_R;
                e.len      = 3'd2;
            end else if (c == 31'(CH_QUOTE) || c == 31'(CH_BACKSLASH)) begin
                enc     = encode(cc);
                e.bytes = {enc.bytes, CH_BACKSLASH};
                e.len   = enc.len + 3'd1;
            end else begin
                enc     = encode(cc);
                e.bytes = {8'h00, enc.bytes};
                e.len   = enc.len;
            end
        end else begin
            enc     = encode(cc);
            e.bytes = {8'h00, enc.bytes};
            e.len   = enc.len;
        end
        return e;
    endfunction

endpackage

@@ rtl/core/utf8_escape_transcoder.sv @@
// utf-8 escape transcoder top level: decode, mode handling, re-encode, output buffer
//
// Takes one utf-8 byte per word (six-byte form, code points up to 31 bits) and returns
// the minimal utf-8 re-encoding, plain, escaped or unescaped as the mode register says.
// A byte is taken into an input register, decoded and expanded in one pass into an
// eight-entry result buffer, which drains one output word per cycle while the output
// is not stalled. Throughput is one input byte per cycle while no byte yields more than
// one output word and the output is not stalled; a byte that yields more words holds
// the input channel until the buffer's single output port has drained them. Sequence
// bytes with no output never hold the input channel. The user must write the mode
// register over the apb port while the stream is idle; the block does not enforce it.
module utf8_escape_transcoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  utf8e_pkg::t_in_word       i_in_data,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output utf8e_pkg::t_out_word      o_out_data,
    // config port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // registers
    logic [1:0]                                r_mode, n_mode;
    logic                                      r_in_valid, n_in_valid;
    utf8e_pkg::t_in_word                       r_in, n_in;
    logic [2:0]                                r_bytes_left, n_bytes_left;
    logic [30:0]                               r_code_accum, n_code_accum;
    logic                                      r_bs_pending, n_bs_pending;
    utf8e_pkg::t_res [utf8e_pkg::MAX_RES-1:0]  r_buf, n_buf;
    logic [3:0]                                r_cnt, n_cnt;
    logic [2:0]                                r_idx, n_idx;
    logic                                      r_out_valid, n_out_valid;

    // decode results
    logic [2:0]                                bl;
    logic [30:0]                               acc_step;
    logic [2:0]                                bl_step;
    logic [30:0]                               st_acc;
    logic [2:0]                                st_bl;
    logic                                      first_valid;
    logic [30:0]                               first_code;
    logic                                      second_valid;
    logic                                      bad;
    logic                                      bp_a;
    logic                                      bp_b;
    logic                                      push_nul;
    utf8e_pkg::t_emit                          ea;
    utf8e_pkg::t_emit                          eb;
    utf8e_pkg::t_res [utf8e_pkg::MAX_RES-1:0]  list;
    logic [3:0]                                cnt;
    logic [3:0]                                pos;

    // handshake
    logic                                      in_accept;
    logic                                      deliver;
    logic                                      is_last;
    logic                                      buf_done;
    logic                                      load;
    logic                                      cfg_write;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == utf8e_pkg::REG_MODE);
    assign prdata    = (paddr[2] == utf8e_pkg::REG_MODE) ? {30'b0, r_mode} : 32'b0;
    assign n_mode    = cfg_write ? pwdata[1:0] : r_mode;

    // handshake control
    assign is_last     = (({1'b0, r_idx} + 4'd1) == r_cnt);
    assign deliver     = r_out_valid && !i_out_stall;
    assign buf_done    = !r_out_valid || (deliver && is_last);
    assign load        = r_in_valid && buf_done;
    assign o_in_stall  = r_in_valid && !buf_done;
    assign in_accept   = i_in_valid && !o_in_stall;

    // input register
    always_comb begin
        n_in       = in_accept ? i_in_data : r_in;
        n_in_valid = in_accept ? 1'b1 : (load ? 1'b0 : r_in_valid);
    end

    // decode the byte against the sequence state
    always_comb begin
        bl           = (r_bytes_left > 3'd5) ? 3'd5 : r_bytes_left;
        acc_step     = {r_code_accum[24:0], r_in.in_byte[5:0]};
        bl_step      = bl - 3'd1;
        st_acc       = r_code_accum;
        st_bl        = bl;
        first_valid  = 1'b0;
        first_code   = '0;
        second_valid = 1'b0;
        bad          = 1'b0;
        if (bl != 3'd0) begin
            if (r_in.in_byte == 8'h00) begin
                // zero inside a sequence: pad, then a nul of its own
                first_valid  = 1'b1;
                first_code   = utf8e_pkg::pad_code(r_code_accum, bl);
                second_valid = 1'b1;
                st_acc       = '0;
                st_bl        = 3'd0;
            end else begin
                st_acc = acc_step;
                st_bl  = bl_step;
                if (bl_step == 3'd0) begin
                    first_valid = 1'b1;
                    first_code  = acc_step;
                    st_acc      = '0;
                end
            end
        end else begin
            priority if (r_in.in_byte < 8'h80) begin
                first_valid = 1'b1;
                first_code  = 31'(r_in.in_byte);
            end else if (r_in.in_byte < 8'hC0) begin
                bad = 1'b1;
            end else if (r_in.in_byte < 8'hE0) begin
                st_acc = 31'(r_in.in_byte[4:0]);
                st_bl  = 3'd1;
            end else if (r_in.in_byte < 8'hF0) begin
                st_acc = 31'(r_in.in_byte[3:0]);
                st_bl  = 3'd2;
            end else if (r_in.in_byte < 8'hF8) begin
                st_acc = 31'(r_in.in_byte[2:0]);
                st_bl  = 3'd3;
            end else if (r_in.in_byte < 8'hFC) begin
                st_acc = 31'(r_in.in_byte[1:0]);
                st_bl  = 3'd4;
            end else begin
                st_acc = 31'(r_in.in_byte[0]);
                st_bl  = 3'd5;
            end
        end
        // end of string flushes an open sequence
        if (r_in.end_of_string && st_bl != 3'd0) begin
            first_valid = 1'b1;
            first_code  = utf8e_pkg::pad_code(st_acc, st_bl);
            st_acc      = '0;
            st_bl       = 3'd0;
        end
    end

    // mode handling of up to two code points, then error and flush words
    always_comb begin
        ea   = utf8e_pkg::emit_char(r_mode, r_bs_pending, first_code);
        bp_a = first_valid ? ea.bs_pending : r_bs_pending;
        if (bad && r_mode == utf8e_pkg::MODE_UNESCAPE) begin
            bp_a = 1'b0;
        end
        eb       = utf8e_pkg::emit_char(r_mode, bp_a, 31'b0);
        bp_b     = second_valid ? eb.bs_pending : bp_a;
        push_nul = r_in.end_of_string && bp_b;

        list = '0;
        cnt  = 4'd0;
        pos  = 4'd0;
        if (first_valid) begin
            for (int j = 0; j < 7; j++) begin
                if (3'(j) < ea.len) begin
                    list[3'(j)].out_byte = ea.bytes[3'(j)];
                end
            end
            cnt = {1'b0, ea.len};
        end
        if (second_valid) begin
            for (int j = 0; j < 7; j++) begin
                pos = cnt + 4'(j);
                if (3'(j) < eb.len && pos < 4'(utf8e_pkg::MAX_RES)) begin
                    list[pos[2:0]].out_byte = eb.bytes[3'(j)];
                end
            end
            cnt = cnt + {1'b0, eb.len};
            if (cnt > 4'(utf8e_pkg::MAX_RES)) begin
                cnt = 4'(utf8e_pkg::MAX_RES);
            end
        end
        if (bad) begin
            list[0].out_byte = 8'h00;
            list[0].bad_lead = 1'b1;
            cnt              = 4'd1;
        end
        if (push_nul && cnt < 4'(utf8e_pkg::MAX_RES)) begin
            list[cnt[2:0]] = '0;
            cnt            = cnt + 4'd1;
        end
    end

    // state and result buffer next values
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_code_accum = r_code_accum;
        n_bs_pending = r_bs_pending;
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        if (deliver) begin
            if (is_last) begin
                n_out_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (load) begin
            n_bytes_left = st_bl;
            n_code_accum = st_acc;
            n_bs_pending = push_nul ? 1'b0 : bp_b;
            n_buf        = list;
            n_cnt        = cnt;
            n_idx        = 3'd0;
            n_out_valid  = (cnt != 4'd0);
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= utf8e_pkg::MODE_TRANSCODE;
            r_in_valid   <= 1'b0;
            r_bytes_left <= 3'd0;
            r_code_accum <= '0;
            r_bs_pending <= 1'b0;
            r_cnt        <= 4'd0;
            r_idx        <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_in_valid   <= n_in_valid;
            r_bytes_left <= n_bytes_left;
            r_code_accum <= n_code_accum;
            r_bs_pending <= n_bs_pending;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_buf <= n_buf;
    end

    // output word
    assign o_out_valid            = r_out_valid;
    assign o_out_data.out_byte    = r_buf[r_idx].out_byte;
    assign o_out_data.bad_lead    = r_buf[r_idx].bad_lead;
    assign o_out_data.last_of_run = is_last;

endmodule

@@ rtl/core/utf8e_checker.sv @@
// port-level checker of the utf-8 escape transcoder and its bind
module utf8e_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  utf8e_pkg::t_out_word  o_out_data
);

    // a stalled output word stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its payload
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output word changed while stalled");

    // with the output side empty the input is never held off
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output buffer");

    // an error word carries a zero byte
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_lead |-> o_out_data.out_byte == 8'h00)
        else $error("error word with nonzero byte");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind utf8_escape_transcoder utf8e_checker u_utf8e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
